/* src/lpmr_pkg.sv */
// Shared types and constants for the length-prefixed message ring.
// Holds operation and status codes and the fixed field widths.
// No dependencies; imported by every module of the block.
package lpmr_pkg;

  // Field widths of the item and result beats.
  localparam int OP_W   = 2;
  localparam int LEN_W  = 10;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_ERROR = 2'd3;

endpackage

/* src/lpmr_ram.sv */
// Byte-wide ring storage: one write port and one read port, registered read data.
// Depends on lpmr_pkg for the byte width.
module lpmr_ram
  import lpmr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/length_prefixed_message_ring.sv */
// Top level of the length-prefixed message ring: control, counters and output register.
// Depends on lpmr_pkg and instantiates lpmr_ram for the byte storage.
//
// Usage: one input channel (in_valid/in_ready) carries op, msg_length and data_in;
// one output channel (out_valid/out_ready) returns status, data_out, last and
// pop_length, exactly one result beat for each input beat, in order.
// A begin (op 0) reserves a header slot plus the message bytes and writes the two
// length bytes of the header; push-byte beats (op 1) then fill the message, which
// becomes visible to the reader when its last byte lands. Pop beats (op 2) return
// the oldest committed message one byte per beat and flag the final byte.
// Steps per item, from acceptance to result in the output register: a push byte
// or any refused item finishes in S_IDLE; an accepted begin writes its two header
// bytes in turn through the single write port (S_IDLE, S_HDR1); a pop byte inside
// an open message reads the ring memory once (S_IDLE, S_POP_D); and the first pop
// byte of a message first reads the two length bytes of the header (S_IDLE,
// S_POP_H1, S_POP_H2, S_POP_D). The block takes one item at a time; in_ready is
// high while it is idle, even when a result waits in the output register. If the
// receiver stalls, a finished result is parked until the output register frees up, and no new item is taken meanwhile.
// Reset clears the counters and open flags; the ring memory is not cleared and
// needs no clearing pass, since only bytes written earlier are ever read.
module length_prefixed_message_ring
  import lpmr_pkg::*;
#(
  parameter int CAPACITY     = 1024,
  parameter int HEADER_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [LEN_W-1:0]  msg_length,
  input  logic [BYTE_W-1:0] data_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [BYTE_W-1:0] data_out,
  output logic              last,
  output logic [LEN_W-1:0]  pop_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 2;

  // Controller state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HDR1   = 3'd1;
  localparam logic [2:0] S_POP_H1 = 3'd2;
  localparam logic [2:0] S_POP_H2 = 3'd3;
  localparam logic [2:0] S_POP_D  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     read_count, read_count_next;
  logic [CW-1:0]     reserve_count, reserve_count_next;
  logic [CW-1:0]     commit_count, commit_count_next;
  logic [LEN_W-1:0]  push_left, push_left_next;
  logic              push_open, push_open_next;
  logic [LEN_W-1:0]  pop_left, pop_left_next;
  logic              pop_open, pop_open_next;
  logic [LEN_W-1:0]  pop_len, pop_len_next;
  logic [AW-1:0]     pop_addr, pop_addr_next;
  logic [LEN_W-1:0]  len_hold, len_hold_next;
  logic [BYTE_W-1:0] hdr_lo, hdr_lo_next;

  // Parked result while the output register is occupied.
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [BYTE_W-1:0] res_data, res_data_next;
  logic              res_last, res_last_next;
  logic [LEN_W-1:0]  res_plen, res_plen_next;

  logic              out_valid_next;
  logic [STAT_W-1:0] status_next;
  logic [BYTE_W-1:0] data_out_next;
  logic              last_next;
  logic [LEN_W-1:0]  pop_length_next;

  // Memory port controls.
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  // Result produced this cycle.
  logic              fin;
  logic [STAT_W-1:0] fin_status;
  logic [BYTE_W-1:0] fin_data;
  logic              fin_last;
  logic [LEN_W-1:0]  fin_plen;

  logic              in_fire, out_free, room_ok;
  logic [CW-1:0]     used, commit_used, byte_pos;
  logic [SW-1:0]     room_sum;
  logic [2*BYTE_W-1:0] hdr_word;
  logic [LEN_W-1:0]  hdr_len;
  logic [AW-1:0]     data_start;

  lpmr_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Occupancy and the room check for a new message.
  assign used        = reserve_count - read_count;
  assign commit_used = commit_count - read_count;
  assign room_sum    = SW'(used) + SW'(msg_length) + SW'(HEADER_BYTES);
  assign room_ok     = room_sum < SW'(CAPACITY - 1);

  // Position of the next data byte of the open push.
  assign byte_pos = reserve_count - CW'(push_left);

  // Length from the two header bytes, and where the message data begins.
  assign hdr_word   = {mem_rdata, hdr_lo};
  assign hdr_len    = hdr_word[LEN_W-1:0];
  assign data_start = read_count[AW-1:0] + AW'(HEADER_BYTES);

  // Next-state logic for the controller, counters and result path.
  always_comb begin
    state_next         = state;
    read_count_next    = read_count;
    reserve_count_next = reserve_count;
    commit_count_next  = commit_count;
    push_left_next     = push_left;
    push_open_next     = push_open;
    pop_left_next      = pop_left;
    pop_open_next      = pop_open;
    pop_len_next       = pop_len;
    pop_addr_next      = pop_addr;
    len_hold_next      = len_hold;
    hdr_lo_next        = hdr_lo;
    res_status_next    = res_status;
    res_data_next      = res_data;
    res_last_next      = res_last;
    res_plen_next      = res_plen;
    out_valid_next     = out_valid && !out_ready;
    status_next        = status;
    data_out_next      = data_out;
    last_next          = last;
    pop_length_next    = pop_length;
    mem_we             = 1'b0;
    mem_waddr          = reserve_count[AW-1:0];
    mem_wdata          = msg_length[BYTE_W-1:0];
    mem_re             = 1'b0;
    mem_raddr          = read_count[AW-1:0];
    fin                = 1'b0;
    fin_status         = ST_OK;
    fin_data           = '0;
    fin_last           = 1'b0;
    fin_plen           = '0;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_BEGIN: begin
              if (push_open || (msg_length == '0)) begin
                fin        = 1'b1;
                fin_status = ST_ERROR;
              end else if (!room_ok) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                // Header byte 0 holds the low length byte.
                mem_we        = 1'b1;
                len_hold_next = msg_length;
                state_next    = S_HDR1;
              end
            end
            OP_BYTE: begin
              fin = 1'b1;
              if (!push_open) begin
                fin_status = ST_ERROR;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = byte_pos[AW-1:0];
                mem_wdata      = data_in;
                push_left_next = push_left - LEN_W'(1);
                if (push_left == LEN_W'(1)) begin
                  push_open_next    = 1'b0;
                  commit_count_next = reserve_count;
                end
              end
            end
            OP_POP: begin
              if (!pop_open && (read_count == commit_count)) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else if (!pop_open) begin
                mem_re     = 1'b1;
                state_next = S_POP_H1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = pop_addr;
                state_next = S_POP_D;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = ST_ERROR;
            end
          endcase
        end
      end
      S_HDR1: begin
        // Header byte 1 holds the high length bits; reserve the whole slot.
        mem_we             = 1'b1;
        mem_waddr          = reserve_count[AW-1:0] + AW'(1);
        mem_wdata          = BYTE_W'(len_hold >> BYTE_W);
        reserve_count_next = CW'(SW'(reserve_count) + SW'(len_hold) + SW'(HEADER_BYTES));
        push_left_next     = len_hold;
        push_open_next     = 1'b1;
        fin                = 1'b1;
      end
      S_POP_H1: begin
        mem_re      = 1'b1;
        mem_raddr   = read_count[AW-1:0] + AW'(1);
        hdr_lo_next = mem_rdata;
        state_next  = S_POP_H2;
      end
      S_POP_H2: begin
        pop_len_next  = hdr_len;
        pop_left_next = hdr_len;
        pop_open_next = 1'b1;
        mem_re        = 1'b1;
        mem_raddr     = data_start;
        pop_addr_next = data_start;
        state_next    = S_POP_D;
      end
      S_POP_D: begin
        fin           = 1'b1;
        fin_data      = mem_rdata;
        fin_plen      = pop_len;
        fin_last      = (pop_left == LEN_W'(1));
        pop_left_next = pop_left - LEN_W'(1);
        pop_addr_next = pop_addr + AW'(1);
        if (pop_left == LEN_W'(1)) begin
          pop_open_next   = 1'b0;
          read_count_next = CW'(SW'(read_count) + SW'(pop_len) + SW'(HEADER_BYTES));
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          status_next     = res_status;
          data_out_next   = res_data;
          last_next       = res_last;
          pop_length_next = res_plen;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Deliver a finished result, or park it if the receiver is stalling.
    if (fin) begin
      if (out_free) begin
        out_valid_next  = 1'b1;
        status_next     = fin_status;
        data_out_next   = fin_data;
        last_next       = fin_last;
        pop_length_next = fin_plen;
        state_next      = S_IDLE;
      end else begin
        res_status_next = fin_status;
        res_data_next   = fin_data;
        res_last_next   = fin_last;
        res_plen_next   = fin_plen;
        state_next      = S_FIN;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      read_count    <= '0;
      reserve_count <= '0;
      commit_count  <= '0;
      push_left     <= '0;
      push_open     <= 1'b0;
      pop_left      <= '0;
      pop_open      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      read_count    <= read_count_next;
      reserve_count <= reserve_count_next;
      commit_count  <= commit_count_next;
      push_left     <= push_left_next;
      push_open     <= push_open_next;
      pop_left      <= pop_left_next;
      pop_open      <= pop_open_next;
      out_valid     <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pop_len    <= pop_len_next;
    pop_addr   <= pop_addr_next;
    len_hold   <= len_hold_next;
    hdr_lo     <= hdr_lo_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_last   <= res_last_next;
    res_plen   <= res_plen_next;
    status     <= status_next;
    data_out   <= data_out_next;
    last       <= last_next;
    pop_length <= pop_length_next;
  end

  // Committed bytes never run ahead of reserved bytes.
  a_commit_within_reserve: assert property (@(posedge clk) disable iff (rst)
    commit_used <= used)
    else $error("commit count ahead of reserve count");

  // Reserved space always stays below the refusal threshold.
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used < CW'(CAPACITY - 1))
    else $error("ring occupancy beyond capacity");

  // An open push always has bytes left to store.
  a_push_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    push_open |-> (push_left != '0))
    else $error("open push with no bytes left");

  // Data reads only happen inside an open pop.
  a_pop_data_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_D) |-> pop_open)
    else $error("pop data read without an open pop");

  // A parked result only exists while the output register is occupied.
  a_fin_out_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> out_valid)
    else $error("parked result with free output register");

endmodule
